@@ design/eg_pkg.sv @@
`default_nettype none
package eg_pkg;

  // Operand width of every modular quantity
  localparam int W = 32;
  // Counter width for a pass over one operand
  localparam int CW = $clog2(W + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;
  localparam logic [1:0] REG_PUBLIC = 2'd3;

  // Command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

endpackage
`default_nettype wire

@@ design/eg_mulmod.sv @@
`default_nettype none
// Bit-serial modular multiplier: res = a * b mod m, one bit of b per cycle,
// msb first. a must already be below m; b may hold any value.
module eg_mulmod import eg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      res
);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  am;
  logic [W-1:0]  bs;
  logic [W:0]    dbl;
  logic [W:0]    dbl_red;
  logic [W:0]    sum;
  logic [W-1:0]  acc_next;

  // Double the accumulator, then add a when the current bit of b is set
  always_comb begin
    dbl = {res, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = dbl_red;
    if (bs[W-1]) begin
      sum = dbl_red + {1'b0, am};
    end
    acc_next = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator shift
  always_ff @(posedge clk) begin
    if (start) begin
      am <= a;
      bs <= b;
      res <= '0;
    end else if (run) begin
      bs <= {bs[W-2:0], 1'b0};
      res <= acc_next;
    end
  end

endmodule
`default_nettype wire

@@ design/eg_divider.sv @@
`default_nettype none
// Restoring bit-serial divider: one quotient bit per cycle. den is nonzero.
module eg_divider import eg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dv;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend through the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dv <= den;
      rem <= '0;
      quo <= num;
    end else if (run) begin
      if (trial >= {1'b0, dv}) begin
        rem <= W'(trial - {1'b0, dv});
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ design/elgamal_encrypt_decrypt.sv @@
`default_nettype none
// ElGamal encrypt/decrypt engine over a 32-bit modulus. A command is taken
// when start is high and busy is low; its one result appears with done high
// for a single cycle and must be captured then. All products run through one
// bit-serial modular multiplier: encryption is two square-and-multiply
// exponentiations plus one product; decryption is one exponentiation, an
// extended Euclid whose steps each take a serial division and one product,
// and a final product. A zero modulus answers in the cycle after the command
// is taken, with all fields zero.
module elgamal_encrypt_decrypt import eg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [W-1:0] cfg_data,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         command,
  input  wire logic [W-1:0] message,
  input  wire logic [W-1:0] ephemeral_exponent,
  input  wire logic [W-1:0] cipher_first_in,
  input  wire logic [W-1:0] cipher_second_in,
  output logic              done,
  output logic [W-1:0]      cipher_first_out,
  output logic [W-1:0]      cipher_second_out,
  output logic [W-1:0]      plain_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRED = 4'd1;
  localparam logic [3:0] S_PREDW = 4'd2;
  localparam logic [3:0] S_PCHK = 4'd3;
  localparam logic [3:0] S_PMUL = 4'd4;
  localparam logic [3:0] S_PMULW = 4'd5;
  localparam logic [3:0] S_PSQ = 4'd6;
  localparam logic [3:0] S_PSQW = 4'd7;
  localparam logic [3:0] S_PEND = 4'd8;
  localparam logic [3:0] S_FMUL = 4'd9;
  localparam logic [3:0] S_FMULW = 4'd10;
  localparam logic [3:0] S_ECHK = 4'd11;
  localparam logic [3:0] S_EDIV = 4'd12;
  localparam logic [3:0] S_EDIVW = 4'd13;
  localparam logic [3:0] S_EMUL = 4'd14;
  localparam logic [3:0] S_EMULW = 4'd15;

  logic [W-1:0] modulus;
  logic [W-1:0] generator;
  logic [W-1:0] private_exponent;
  logic [W-1:0] public_value;

  logic [3:0]   state;
  logic         cmd;
  logic         phase;
  logic [W-1:0] pow_src;
  logic [W-1:0] ex;
  logic [W-1:0] rexp;
  logic [W-1:0] base;
  logic [W-1:0] acc;
  logic [W-1:0] fin_b;
  logic [W-1:0] c1r;
  logic [W-1:0] rhi;
  logic [W-1:0] rlo;
  logic [W-1:0] chi;
  logic [W-1:0] clo;
  logic [W-1:0] q;
  logic [W-1:0] rnew;

  logic [W-1:0] one_mod;
  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_res;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic [W-1:0] neg_prod;
  logic [W:0]   csum;
  logic [W-1:0] c_next;
  logic         accept;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign one_mod = (modulus == W'(1)) ? '0 : W'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(11);
      generator <= W'(2);
      private_exponent <= W'(3);
      public_value <= W'(8);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODULUS:   modulus <= cfg_data;
        REG_GENERATOR: generator <= cfg_data;
        REG_PRIV_EXP:  private_exponent <= cfg_data;
        REG_PUBLIC:    public_value <= cfg_data;
        default:       modulus <= cfg_data;
      endcase
    end
  end

  // Select multiplier operands by step
  always_comb begin
    mul_start = 1'b0;
    mul_a = acc;
    mul_b = base;
    div_start = (state == S_EDIV);
    unique case (state)
      S_PRED: begin
        mul_start = 1'b1;
        mul_a = one_mod;
        mul_b = pow_src;
      end
      S_PMUL: begin
        mul_start = 1'b1;
      end
      S_PSQ: begin
        mul_start = 1'b1;
        mul_a = base;
      end
      S_FMUL: begin
        mul_start = 1'b1;
        mul_a = (cmd == CMD_DECRYPT) ? chi : acc;
        mul_b = fin_b;
      end
      S_EMUL: begin
        mul_start = 1'b1;
        mul_a = clo;
        mul_b = q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Bezout coefficient update: c_hi - q * c_lo mod p
  always_comb begin
    neg_prod = (mul_res == '0) ? '0 : modulus - mul_res;
    csum = {1'b0, chi} + {1'b0, neg_prod};
    c_next = (csum >= {1'b0, modulus}) ? W'(csum - {1'b0, modulus}) : csum[W-1:0];
  end

  eg_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus),
    .done  (mul_done),
    .res   (mul_res)
  );

  eg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rhi),
    .den   (rlo),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (modulus == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_PRED;
            end
          end
        end
        S_PRED:  state <= S_PREDW;
        S_PREDW: if (mul_done) state <= S_PCHK;
        S_PCHK: begin
          if (ex == '0) begin
            state <= S_PEND;
          end else if (ex[0]) begin
            state <= S_PMUL;
          end else begin
            state <= S_PSQ;
          end
        end
        S_PMUL:  state <= S_PMULW;
        S_PMULW: if (mul_done) state <= S_PSQ;
        S_PSQ:   state <= S_PSQW;
        S_PSQW:  if (mul_done) state <= S_PCHK;
        S_PEND: begin
          if (cmd == CMD_DECRYPT) begin
            state <= S_ECHK;
          end else if (!phase) begin
            state <= S_PRED;
          end else begin
            state <= S_FMUL;
          end
        end
        S_FMUL: state <= S_FMULW;
        S_FMULW: begin
          if (mul_done) begin
            state <= S_IDLE;
            done <= 1'b1;
          end
        end
        S_ECHK:  state <= (rlo == '0) ? S_FMUL : S_EDIV;
        S_EDIV:  state <= S_EDIVW;
        S_EDIVW: if (div_done) state <= S_EMUL;
        S_EMUL:  state <= S_EMULW;
        S_EMULW: if (mul_done) state <= S_ECHK;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd <= command;
          phase <= 1'b0;
          pow_src <= command ? cipher_first_in : generator;
          ex <= command ? private_exponent : ephemeral_exponent;
          rexp <= ephemeral_exponent;
          fin_b <= command ? cipher_second_in : message;
          cipher_first_out <= '0;
          cipher_second_out <= '0;
          plain_out <= '0;
        end
      end
      S_PREDW: begin
        if (mul_done) begin
          base <= mul_res;
          acc <= one_mod;
        end
      end
      S_PMULW: if (mul_done) acc <= mul_res;
      S_PSQW: begin
        if (mul_done) begin
          base <= mul_res;
          ex <= {1'b0, ex[W-1:1]};
        end
      end
      S_PEND: begin
        if (cmd == CMD_DECRYPT) begin
          rhi <= modulus;
          rlo <= acc;
          chi <= '0;
          clo <= one_mod;
        end else if (!phase) begin
          c1r <= acc;
          phase <= 1'b1;
          pow_src <= public_value;
          ex <= rexp;
        end
      end
      S_FMULW: begin
        if (mul_done) begin
          if (cmd == CMD_DECRYPT) begin
            plain_out <= mul_res;
          end else begin
            cipher_first_out <= c1r;
            cipher_second_out <= mul_res;
          end
        end
      end
      S_EDIVW: begin
        if (div_done) begin
          q <= div_quo;
          rnew <= div_rem;
        end
      end
      S_EMULW: begin
        if (mul_done) begin
          rhi <= rlo;
          rlo <= rnew;
          chi <= clo;
          clo <= c_next;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A zero modulus answers at once
  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    accept && (modulus == '0) |=> done && (plain_out == '0))
    else $error("zero modulus did not answer at once");

  // A result is only reported as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while busy");

  // A real command keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (modulus != '0) |=> busy)
    else $error("command accepted without going busy");
`endif

endmodule
`default_nettype wire
